>>> design/utcc_pkg.sv
// Shared types, codes, leap-second tables and divider constants of the time converter.
`default_nettype none

package utcc_pkg;

   // Conversion codes
   localparam logic [1:0] OP_CAL2MJD = 2'd0;
   localparam logic [1:0] OP_MJD2CAL = 2'd1;
   localparam logic [1:0] OP_UTC2GPS = 2'd2;
   localparam logic [1:0] OP_GPS2UTC = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_OK    = 3'd0;
   localparam logic [2:0] ERR_CAL   = 3'd1;
   localparam logic [2:0] ERR_MJD   = 3'd2;
   localparam logic [2:0] ERR_WEEK  = 3'd3;
   localparam logic [2:0] ERR_EPOCH = 3'd4;

   localparam logic [26:0] MS_PER_DAY   = 27'd86400000;
   localparam logic [29:0] MS_PER_WEEK  = 30'd604800000;
   localparam logic [17:0] MJD_LOW      = 18'd15079;
   localparam logic [17:0] MJD_HIGH     = 18'd88127;
   localparam logic [17:0] MJD_GPS_ZERO = 18'd44244;

   localparam int LEAP_ROM_SIZE = 28;

   localparam logic [16:0] LEAP_DAY_TAB [LEAP_ROM_SIZE] = '{
      17'd41317, 17'd41499, 17'd41683, 17'd42048, 17'd42413, 17'd42778, 17'd43144,
      17'd43509, 17'd43874, 17'd44239, 17'd44786, 17'd45151, 17'd45516, 17'd46247,
      17'd47161, 17'd47892, 17'd48257, 17'd48804, 17'd49169, 17'd49534, 17'd50083,
      17'd50630, 17'd51179, 17'd53736, 17'd54832, 17'd56109, 17'd57204, 17'd57754
   };

   localparam logic [5:0] LEAP_VAL_TAB [LEAP_ROM_SIZE] = '{
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10,
      6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18
   };

   // Reciprocal constants: floor(x / D) == (x * M) >> S for x below 2**N,
   // with S = N + ceil(log2 D) and M = ceil(2**S / D).
   localparam int S_HR = 49;  // 27-bit ms of day / 3600000
   localparam logic [27:0] M_HR =
      28'(((64'd1 << S_HR) + 64'd3599999) / 64'd3600000);
   localparam int S_MN = 38;  // 22-bit ms of hour / 60000
   localparam logic [22:0] M_MN =
      23'(((64'd1 << S_MN) + 64'd59999) / 64'd60000);
   localparam int S_CD = 31;  // 20-bit 4c+3 / 1461
   localparam logic [20:0] M_CD =
      21'(((64'd1 << S_CD) + 64'd1460) / 64'd1461);
   localparam int S_W7 = 20;  // 17-bit day count / 7
   localparam logic [17:0] M_W7 =
      18'(((64'd1 << S_W7) + 64'd6) / 64'd7);

   // Century boundaries of 4a+3 for the Gregorian cycle split
   localparam logic [23:0] CENT_68 = 24'(146097 * 68);
   localparam logic [23:0] CENT_69 = 24'(146097 * 69);

   typedef struct packed {
      logic [1:0]  opcode;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] ms_of_minute;
      logic [16:0] mjd_day;
      logic [26:0] ms_of_day;
      logic [12:0] gps_week;
      logic [29:0] gps_ms_of_week;
   } req_type;

   typedef struct packed {
      logic [11:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [15:0] out_ms_of_minute;
      logic [16:0] out_mjd_day;
      logic [26:0] out_ms_of_day;
      logic [12:0] out_gps_week;
      logic [29:0] out_gps_ms_of_week;
      logic [5:0]  leap_seconds;
      logic [2:0]  error_code;
   } rsp_type;

   // Offset of the last table entry passed, from the count of entries passed
   function automatic logic [5:0] leap_value(input logic [5:0] cnt);
      logic [5:0] idx;
      idx = cnt - 6'd1;
      if (cnt == 6'd0) begin
         return 6'd0;
      end else if (int'(cnt) > LEAP_ROM_SIZE) begin
         return LEAP_VAL_TAB[LEAP_ROM_SIZE-1];
      end else begin
         return LEAP_VAL_TAB[idx[4:0]];
      end
   endfunction

   // floor(30.6001 * k) for k = month + 1, months counted 3 to 14
   function automatic logic [8:0] month_term(input logic [4:0] k);
      logic [8:0] v;
      case (k)
         5'd4:    v = 9'd122;
         5'd5:    v = 9'd153;
         5'd6:    v = 9'd183;
         5'd7:    v = 9'd214;
         5'd8:    v = 9'd244;
         5'd9:    v = 9'd275;
         5'd10:   v = 9'd306;
         5'd11:   v = 9'd336;
         5'd12:   v = 9'd367;
         5'd13:   v = 9'd397;
         5'd14:   v = 9'd428;
         5'd15:   v = 9'd459;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // (153 * mm + 2) / 5: day offset of a March-based month
   function automatic logic [8:0] month_start(input logic [3:0] mm);
      logic [8:0] v;
      case (mm)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd31;
         4'd2:    v = 9'd61;
         4'd3:    v = 9'd92;
         4'd4:    v = 9'd122;
         4'd5:    v = 9'd153;
         4'd6:    v = 9'd184;
         4'd7:    v = 9'd214;
         4'd8:    v = 9'd245;
         4'd9:    v = 9'd275;
         4'd10:   v = 9'd306;
         4'd11:   v = 9'd337;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> design/utcc_leap_count.sv
// Leap-second table search: counts the switch-over days not after a given day.
`default_nettype none

module utcc_leap_count
   import utcc_pkg::*;
#(
   parameter int LEAP_ENTRIES = 28
) (
   input  wire logic [17:0] day,
   output logic [5:0]       count
);

   localparam int LEAP_USED = (LEAP_ENTRIES < LEAP_ROM_SIZE) ? LEAP_ENTRIES : LEAP_ROM_SIZE;

   logic [LEAP_ROM_SIZE-1:0] hit;

   // Table is sorted, so the passed entries form a prefix
   always_comb begin
      for (int i = 0; i < LEAP_ROM_SIZE; i++) begin
         hit[i] = (i < LEAP_USED) && (day >= {1'b0, LEAP_DAY_TAB[i]});
      end
      count = 6'($countones(hit));
   end

endmodule

`default_nettype wire

>>> design/utc_calendar_mjd_gps_converter.sv
// Top level of the calendar / MJD / GPS week time converter pipeline.
`default_nettype none

// Converts one time request per clock: calendar to MJD, MJD to calendar,
// UTC to GPS week and ms of week, and GPS back to UTC, selected by opcode.
// Each request passes through every stage on its way to the response; the
// pipeline is ten register stages, the longest path being one constant
// reciprocal multiply (hours, minutes, Gregorian year split, week split).
// A new request is accepted every cycle while the response side takes
// results; when rsp_ready is low with a response waiting, the whole
// pipeline holds and req_ready drops. Errors zero every result field but
// error_code. The block keeps no state between requests and needs no
// start-up sweep: it is ready the cycle after reset is released.
// LEAP_ENTRIES limits how many of the 28 leap-second table entries count.

module utc_calendar_mjd_gps_converter
   import utcc_pkg::*;
#(
   parameter int LEAP_ENTRIES = 28
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int NUM_STAGES = 10;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  err;
      logic [17:0] day;   // working UTC day
      logic [26:0] ms;    // working ms of day
      logic [12:0] wk;    // GPS week input
      logic [29:0] sow;   // GPS ms of week input
      logic [5:0]  lcnt;
      logic [5:0]  lp;
      logic [16:0] gd;    // days since GPS epoch
      logic [26:0] gms;   // ms of GPS day
      logic [14:0] gw;
      logic [2:0]  dow;
      logic [29:0] gsow;
      logic [21:0] ca;
      logic [6:0]  cb;
      logic [17:0] cc;
      logic [8:0]  cd;
      logic [8:0]  ce;
      logic [3:0]  cmm;
      logic [4:0]  hr;
      logic [21:0] remh;
      logic [5:0]  mn;
      logic [15:0] msm;
   } pipe_type;

   logic [NUM_STAGES-1:0] vld_ff;
   logic                  adv;

   pipe_type st1_in, st1_ff, st2_in, st2_ff, st3_in, st3_ff, st4_in, st4_ff;
   pipe_type st5_in, st5_ff, st6_in, st6_ff, st7_in, st7_ff, st8_in, st8_ff;
   pipe_type st9_in, st9_ff;
   rsp_type  rsp_in, rsp_ff;
   logic [5:0] leap_cnt;

   // Advance everything unless a finished response is stuck
   assign adv       = !vld_ff[NUM_STAGES-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
         st3_ff <= st3_in;
         st4_ff <= st4_in;
         st5_ff <= st5_in;
         st6_ff <= st6_in;
         st7_ff <= st7_in;
         st8_ff <= st8_in;
         st9_ff <= st9_in;
         rsp_ff <= rsp_in;
      end
   end

   // Stage 1: field checks, calendar sums, day carry, split of the GPS week
   always_comb begin : stage1
      logic [11:0] ya;
      logic [4:0]  ma;
      logic [4:0]  cent;
      logic [4:0]  cent4;
      logic [23:0] jprod;
      logic [23:0] dsum;
      logic [5:0]  dayhit;
      logic [2:0]  q;
      st1_in     = '0;
      st1_in.op  = req_data.opcode;
      st1_in.err = ERR_OK;
      st1_in.wk  = req_data.gps_week;
      st1_in.sow = req_data.gps_ms_of_week;
      ya    = req_data.year;
      ma    = {1'b0, req_data.month};
      if (req_data.month <= 4'd2) begin
         ya = req_data.year - 12'd1;
         ma = {1'b0, req_data.month} + 5'd12;
      end
      cent  = 5'd18 + 5'(ya >= 12'd1900) + 5'(ya >= 12'd2000) + 5'(ya >= 12'd2100);
      cent4 = (ya >= 12'd2000) ? 5'd5 : 5'd4;
      jprod = (24'(ya) + 24'd4716) * 24'd1461;
      dsum  = (jprod >> 2) + 24'(month_term(ma + 5'd1)) + 24'(req_data.day) + 24'd2
              + 24'(cent4) - 24'(cent) - 24'd2401525;
      for (int k = 0; k < 6; k++) begin
         dayhit[k] = req_data.gps_ms_of_week >= 30'(86400000 * (k + 1));
      end
      q = 3'($countones(dayhit));
      case (req_data.opcode)
         OP_CAL2MJD: begin
            if (req_data.year < 12'd1900 || req_data.year > 12'd2100 ||
                req_data.month < 4'd1 || req_data.month > 4'd12 ||
                req_data.day < 5'd1 || req_data.hour > 5'd23 ||
                req_data.minute > 6'd59 || req_data.ms_of_minute >= 16'd61000) begin
               st1_in.err = ERR_CAL;
            end
            st1_in.day = dsum[17:0];
            st1_in.ms  = 27'(req_data.hour) * 27'd3600000 + 27'(req_data.minute) * 27'd60000
                         + 27'(req_data.ms_of_minute);
         end
         OP_MJD2CAL, OP_UTC2GPS: begin
            st1_in.day = {1'b0, req_data.mjd_day};
            st1_in.ms  = req_data.ms_of_day;
            if (req_data.ms_of_day >= MS_PER_DAY) begin
               st1_in.day = {1'b0, req_data.mjd_day} + 18'd1;
               st1_in.ms  = req_data.ms_of_day - MS_PER_DAY;
            end
         end
         default: begin
            if (req_data.gps_ms_of_week >= MS_PER_WEEK) begin
               st1_in.err = ERR_WEEK;
            end
            st1_in.ms  = 27'(req_data.gps_ms_of_week - 30'(q) * 30'd86400000);
            st1_in.day = MJD_GPS_ZERO + 18'(req_data.gps_week) * 18'd7 + 18'(q);
         end
      endcase
   end

   utcc_leap_count #(
      .LEAP_ENTRIES(LEAP_ENTRIES)
   ) u_leap (
      .day  (st1_ff.day),
      .count(leap_cnt)
   );

   // Stage 2: calendar day carry, MJD range check, leap table search
   always_comb begin
      st2_in      = st1_ff;
      st2_in.lcnt = leap_cnt;
      if (st1_ff.op == OP_CAL2MJD && st1_ff.ms >= MS_PER_DAY) begin
         st2_in.ms  = st1_ff.ms - MS_PER_DAY;
         st2_in.day = st1_ff.day + 18'd1;
      end
      if ((st1_ff.op == OP_MJD2CAL || st1_ff.op == OP_UTC2GPS) && st1_ff.err == ERR_OK &&
          (st1_ff.day < MJD_LOW || st1_ff.day > MJD_HIGH)) begin
         st2_in.err = ERR_MJD;
      end
   end

   // Stage 3: leap offset
   always_comb begin
      st3_in    = st2_ff;
      st3_in.lp = leap_value(st2_ff.lcnt);
   end

   // Stage 4: apply the offset, borrow or carry a day
   always_comb begin : stage4
      logic [16:0] lpms;
      logic [26:0] gsum;
      logic [18:0] gfull;
      st4_in = st3_ff;
      lpms   = 17'(st3_ff.lp) * 17'd1000;
      gsum   = st3_ff.ms + 27'(lpms);
      gfull  = 19'(st3_ff.day);
      if (gsum >= MS_PER_DAY) begin
         gsum  = gsum - MS_PER_DAY;
         gfull = gfull + 19'd1;
      end
      st4_in.gms = gsum;
      st4_in.gd  = 17'(gfull - 19'(MJD_GPS_ZERO));
      if (st3_ff.op == OP_UTC2GPS && st3_ff.err == ERR_OK && gfull < 19'(MJD_GPS_ZERO)) begin
         st4_in.err = ERR_EPOCH;
      end
      if (st3_ff.op == OP_GPS2UTC) begin
         if (st3_ff.ms < 27'(lpms)) begin
            st4_in.ms  = st3_ff.ms + MS_PER_DAY - 27'(lpms);
            st4_in.day = st3_ff.day - 18'd1;
         end else begin
            st4_in.ms = st3_ff.ms - 27'(lpms);
         end
      end
   end

   // Stage 5: GPS range check, century split, hour and week quotients
   always_comb begin : stage5
      logic [23:0] x4;
      logic [54:0] hp;
      logic [34:0] wp;
      st5_in = st4_ff;
      if (st4_ff.op == OP_GPS2UTC && st4_ff.err == ERR_OK &&
          (st4_ff.day < MJD_LOW || st4_ff.day > MJD_HIGH)) begin
         st5_in.err = ERR_MJD;
      end
      st5_in.ca = 22'(st4_ff.day) + 22'd2432045;
      x4        = {st5_in.ca, 2'b11};
      st5_in.cb = 7'd67 + 7'(x4 >= CENT_68) + 7'(x4 >= CENT_69);
      hp        = 55'(st4_ff.ms) * 55'(M_HR);
      st5_in.hr = hp[S_HR +: 5];
      wp        = 35'(st4_ff.gd) * 35'(M_W7);
      st5_in.gw = wp[S_W7 +: 15];
   end

   // Stage 6: remainders of the century, hour and week splits
   always_comb begin : stage6
      logic [23:0] cprod;
      st6_in      = st5_ff;
      cprod       = (24'(st5_ff.cb) * 24'd146097) >> 2;
      st6_in.cc   = 18'(st5_ff.ca - cprod[21:0]);
      st6_in.remh = 22'(st5_ff.ms - 27'(st5_ff.hr) * 27'd3600000);
      st6_in.dow  = 3'(st5_ff.gd - 17'(st5_ff.gw) * 17'd7);
   end

   // Stage 7: year-in-century and minute quotients, GPS ms of week
   always_comb begin : stage7
      logic [40:0] dp;
      logic [44:0] mp;
      st7_in      = st6_ff;
      dp          = 41'({st6_ff.cc, 2'b11}) * 41'(M_CD);
      st7_in.cd   = dp[S_CD +: 9];
      mp          = 45'(st6_ff.remh) * 45'(M_MN);
      st7_in.mn   = mp[S_MN +: 6];
      st7_in.gsow = 30'(st6_ff.dow) * 30'd86400000 + 30'(st6_ff.gms);
   end

   // Stage 8: day of year, ms of minute
   always_comb begin : stage8
      logic [19:0] yprod;
      st8_in     = st7_ff;
      yprod      = (20'(st7_ff.cd) * 20'd1461) >> 2;
      st8_in.ce  = 9'(st7_ff.cc - yprod[17:0]);
      st8_in.msm = 16'(st7_ff.remh - 22'(st7_ff.mn) * 22'd60000);
   end

   // Stage 9: March-based month from the day of year
   always_comb begin : stage9
      logic [11:0] x5;
      logic [10:0] mhit;
      st9_in = st8_ff;
      x5     = 12'(st8_ff.ce) * 12'd5 + 12'd2;
      for (int k = 0; k < 11; k++) begin
         mhit[k] = x5 >= 12'(153 * (k + 1));
      end
      st9_in.cmm = 4'($countones(mhit));
   end

   // Stage 10: assemble the response, zero what the opcode does not produce
   always_comb begin : stage10
      logic        late;
      logic [13:0] ysum;
      logic [11:0] cyear;
      logic [3:0]  cmonth;
      logic [8:0]  dsum;
      late   = st9_ff.cmm >= 4'd10;
      ysum   = 14'(st9_ff.cb) * 14'd100 + 14'(st9_ff.cd) + 14'(late) - 14'd4800;
      cyear  = ysum[11:0];
      cmonth = late ? st9_ff.cmm - 4'd9 : st9_ff.cmm + 4'd3;
      dsum   = st9_ff.ce - month_start(st9_ff.cmm) + 9'd1;
      rsp_in            = '0;
      rsp_in.error_code = st9_ff.err;
      if (st9_ff.err == ERR_OK) begin
         rsp_in.out_mjd_day   = st9_ff.day[16:0];
         rsp_in.out_ms_of_day = st9_ff.ms;
         if (st9_ff.op == OP_MJD2CAL || st9_ff.op == OP_GPS2UTC) begin
            rsp_in.out_year         = cyear;
            rsp_in.out_month        = cmonth;
            rsp_in.out_day          = dsum[4:0];
            rsp_in.out_hour         = st9_ff.hr;
            rsp_in.out_minute       = st9_ff.mn;
            rsp_in.out_ms_of_minute = st9_ff.msm;
         end
         if (st9_ff.op == OP_UTC2GPS) begin
            rsp_in.out_gps_week       = st9_ff.gw[12:0];
            rsp_in.out_gps_ms_of_week = st9_ff.gsow;
            rsp_in.leap_seconds       = st9_ff.lp;
         end
         if (st9_ff.op == OP_GPS2UTC) begin
            rsp_in.out_gps_week       = st9_ff.wk;
            rsp_in.out_gps_ms_of_week = st9_ff.sow;
            rsp_in.leap_seconds       = st9_ff.lp;
         end
      end
   end

`ifndef ASSERT_OFF
   a_err_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error_code != ERR_OK) |->
         (rsp_data.out_mjd_day == '0 && rsp_data.out_ms_of_day == '0 &&
          rsp_data.out_year == '0 && rsp_data.out_gps_week == '0 &&
          rsp_data.leap_seconds == '0))
      else $error("error response carries nonzero result fields");

   a_ok_ms_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error_code == ERR_OK) |-> (rsp_data.out_ms_of_day < MS_PER_DAY))
      else $error("ms of day not normalized");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted request lost at pipeline entry");

   a_leap_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.leap_seconds <= LEAP_VAL_TAB[LEAP_ROM_SIZE-1]))
      else $error("leap offset beyond table");
`endif

endmodule

`default_nettype wire

>>> tb/time_conv_checker.sv
// Checker for the time converter: predicts each response from its request and compares.
`default_nettype none

module time_conv_checker
   import utcc_pkg::*;
#(
   parameter int LEAP_ENTRIES = 28
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type conv_queue[$];

   function automatic longint gps_minus_utc(input longint mjd);
      longint off;
      int n;
      off = 0;
      n = (LEAP_ENTRIES < LEAP_ROM_SIZE) ? LEAP_ENTRIES : LEAP_ROM_SIZE;
      for (int i = 0; i < n; i++) begin
         if (mjd >= longint'(LEAP_DAY_TAB[i])) off = longint'(LEAP_VAL_TAB[i]);
         else break;
      end
      return off;
   endfunction

   // Fill the calendar fields of r from an MJD and ms of day
   function automatic void mjd_to_cal(input longint mjd, input longint ms, inout rsp_type r);
      longint a, b, c, d, e, mm;
      a = mjd + 2400001 + 32044;
      b = (4 * a + 3) / 146097;
      c = a - (146097 * b) / 4;
      d = (4 * c + 3) / 1461;
      e = c - (1461 * d) / 4;
      mm = (5 * e + 2) / 153;
      r.out_day = 5'(e - (153 * mm + 2) / 5 + 1);
      r.out_month = 4'(mm + 3 - 12 * (mm / 10));
      r.out_year = 12'(100 * b + d - 4800 + mm / 10);
      r.out_hour = 5'(ms / 3600000);
      r.out_minute = 6'((ms % 3600000) / 60000);
      r.out_ms_of_minute = 16'(ms % 60000);
   endfunction

   function automatic rsp_type convert_time(input req_type q);
      rsp_type r;
      longint y, m, dd, day, ms, a, bb, lp, tot;
      r = '0;
      case (q.opcode)
         OP_CAL2MJD: begin
            y = q.year;
            m = q.month;
            dd = q.day;
            if (y < 1900 || y > 2100 || m < 1 || m > 12 || dd < 1 || q.hour > 23 ||
                q.minute > 59 || q.ms_of_minute >= 61000) begin
               r.error_code = ERR_CAL;
            end else begin
               if (m <= 2) begin
                  y -= 1;
                  m += 12;
               end
               a = y / 100;
               bb = 2 - a + a / 4;
               day = (1461 * (y + 4716)) / 4 + (306001 * (m + 1)) / 10000 + dd + bb - 2401525;
               ms = longint'(q.hour) * 3600000 + longint'(q.minute) * 60000
                    + longint'(q.ms_of_minute);
               if (ms >= 86400000) begin
                  ms -= 86400000;
                  day += 1;
               end
               r.out_mjd_day = 17'(day);
               r.out_ms_of_day = 27'(ms);
            end
         end
         OP_MJD2CAL, OP_UTC2GPS: begin
            day = q.mjd_day;
            ms = q.ms_of_day;
            if (ms >= 86400000) begin
               ms -= 86400000;
               day += 1;
            end
            if (day < 15079 || day > 88127) begin
               r.error_code = ERR_MJD;
            end else if (q.opcode == OP_MJD2CAL) begin
               mjd_to_cal(day, ms, r);
               r.out_mjd_day = 17'(day);
               r.out_ms_of_day = 27'(ms);
            end else begin
               lp = gps_minus_utc(day);
               tot = (day - 44244) * 86400000 + ms + lp * 1000;
               if (tot < 0) begin
                  r.error_code = ERR_EPOCH;
               end else begin
                  r.out_mjd_day = 17'(day);
                  r.out_ms_of_day = 27'(ms);
                  r.out_gps_week = 13'(tot / 604800000);
                  r.out_gps_ms_of_week = 30'(tot % 604800000);
                  r.leap_seconds = 6'(lp);
               end
            end
         end
         default: begin
            if (q.gps_ms_of_week >= 604800000) begin
               r.error_code = ERR_WEEK;
            end else begin
               tot = longint'(q.gps_week) * 604800000 + longint'(q.gps_ms_of_week);
               day = 44244 + tot / 86400000;
               ms = tot % 86400000;
               lp = gps_minus_utc(day);
               ms -= lp * 1000;
               if (ms < 0) begin
                  ms += 86400000;
                  day -= 1;
               end
               if (day < 15079 || day > 88127) begin
                  r.error_code = ERR_MJD;
               end else begin
                  mjd_to_cal(day, ms, r);
                  r.out_mjd_day = 17'(day);
                  r.out_ms_of_day = 27'(ms);
                  r.out_gps_week = q.gps_week;
                  r.out_gps_ms_of_week = q.gps_ms_of_week;
                  r.leap_seconds = 6'(lp);
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) conv_queue.push_back(convert_time(req_data));
         if (rsp_valid && rsp_ready) begin
            if (conv_queue.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = conv_queue.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= conv_queue.size();
   end
endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench top for the time converter: stimulus, response stalls and verdict.
`default_nettype none

module tb;
   import utcc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      idle_pct = 16;     // idle chance in percent for both sides
   bit      hold_rsp = 1'b0;   // long receiver hold-off in progress

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   utc_calendar_mjd_gps_converter i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   time_conv_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Randomly stall the response side; drop ready entirely during a hold-off
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_rsp && ($urandom_range(99) >= idle_pct);
   end

   // Offer one request, then hold it until the handshake lands; valid stays
   // high afterwards so the next request can follow with no gap
   task automatic send_request(input req_type q);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic req_type rand_request();
      req_type q;
      q = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      // Bias most requests into the valid ranges so the conversions get exercised
      if ($urandom_range(9) < 8) begin
         q.year = 12'($urandom_range(2100, 1900));
         q.month = 4'($urandom_range(12, 1));
         q.day = 5'($urandom_range(31, 1));
         q.hour = 5'($urandom_range(23));
         q.minute = 6'($urandom_range(59));
         q.ms_of_minute = 16'($urandom_range(60999));
         q.mjd_day = 17'($urandom_range(88200, 15000));
         q.ms_of_day = 27'($urandom_range(($urandom_range(9) == 0) ? 134217727 : 86399999));
         q.gps_week = 13'(($urandom_range(3) == 0) ? $urandom_range(8191) :
                          $urandom_range(6300));
         q.gps_ms_of_week = 30'(($urandom_range(9) == 0) ? $urandom :
                                $urandom_range(604799999));
      end
      return q;
   endfunction

   function automatic req_type make_cal(input int y, m, d, h, mi, s);
      req_type q;
      q = '0;
      q.opcode = OP_CAL2MJD;
      q.year = 12'(y);
      q.month = 4'(m);
      q.day = 5'(d);
      q.hour = 5'(h);
      q.minute = 6'(mi);
      q.ms_of_minute = 16'(s);
      return q;
   endfunction

   function automatic req_type make_utc(input logic [1:0] op, input int mjd, input int ms);
      req_type q;
      q = '0;
      q.opcode = op;
      q.mjd_day = 17'(mjd);
      q.ms_of_day = 27'(ms);
      return q;
   endfunction

   function automatic req_type make_gps(input int wk, input int sow);
      req_type q;
      q = '0;
      q.opcode = OP_GPS2UTC;
      q.gps_week = 13'(wk);
      q.gps_ms_of_week = 30'(sow);
      return q;
   endfunction

   initial begin
      req_type q;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, each opcode and the named corner cases
      send_request(make_cal(1900, 1, 1, 0, 0, 0));
      send_request(make_cal(2100, 12, 31, 23, 59, 60999));   // leap second carries a day
      send_request(make_cal(1899, 6, 1, 0, 0, 0));           // bad year
      send_request(make_cal(2000, 0, 1, 0, 0, 0));           // bad month
      send_request(make_cal(2000, 13, 1, 0, 0, 0));
      send_request(make_cal(2000, 2, 0, 0, 0, 0));           // bad day
      send_request(make_cal(2001, 2, 31, 24, 60, 61000));    // several bad fields
      send_request(make_cal(2000, 2, 31, 12, 0, 0));         // day runs past month end
      send_request(make_utc(OP_MJD2CAL, 15079, 0));
      send_request(make_utc(OP_MJD2CAL, 88127, 86399999));
      send_request(make_utc(OP_MJD2CAL, 88127, 86400000));   // carry out of range
      send_request(make_utc(OP_MJD2CAL, 15078, 86400000));   // carry into range
      send_request(make_utc(OP_MJD2CAL, 131071, 134217727));
      send_request(make_utc(OP_UTC2GPS, 44243, 86399999));   // before epoch
      send_request(make_utc(OP_UTC2GPS, 44244, 0));
      send_request(make_utc(OP_UTC2GPS, 57754, 0));          // last leap switch
      send_request(make_utc(OP_UTC2GPS, 44786, 0));
      send_request(make_utc(OP_UTC2GPS, 15079, 0));
      send_request(make_gps(0, 0));                          // GPS epoch itself
      send_request(make_gps(8191, 604799999));
      send_request(make_gps(100, 604800000));                // bad week ms
      send_request(make_gps(1929, 18000));                   // near a leap switch
      send_request(make_gps(0, 1073741823));

      // Random, with a no-idle stretch and a long receiver hold-off
      for (int n = 0; n < 1700; n++) begin
         if (n == 300) idle_pct = 0;
         if (n == 600) idle_pct = 16;
         if (n == 900) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (60) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         if (n == 1200) begin
            // Sender pause until drained
            req_valid <= 1'b0;
            wait (pending_count == 0);
            @(negedge clock);
         end
         send_request(rand_request());
      end

      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

`default_nettype wire
